// File: rtl/gpsd_pkg.sv
// Shared constants and codes for the depth-first path search block.
package gpsd_pkg;

  localparam int EDGES = 2048;
  localparam int NODE_W = 6;
  localparam int EDGE_W = 2 * NODE_W;
  localparam int EDGE_AW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int EDGE_CW = $clog2(EDGES + 1);
  localparam int STACK_SLOTS = 1 << NODE_W;
  localparam int STACK_AW = NODE_W;
  localparam int DEPTH_W = NODE_W + 1;
  localparam int FRAME_W = NODE_W + EDGE_CW;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOPATH = 2'd2;

endpackage

// File: rtl/gpsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/graph_path_search_dfs_top.sv
// Depth-first path search engine over an edge list held in RAM.
//
//   channel   handshake         fields
//   --------  ----------------  ---------------------------
//   command   start / busy      opcode, node_a, node_b
//   result    strobe (1 cycle)  path_node, status, last
//
// Loads and clears leave busy low; a load into a full store answers with
// one result item in the next cycle. A search reads one edge per cycle
// each time a node is entered or resumed; a node whose edges run out
// passes through S_POP, which reloads the parent frame from the stack,
// before the parent resumes. A found path is emitted one item per cycle,
// target first. Reset is synchronous and clears the edge count and the
// search state. Results cannot be stalled by the receiver.
module graph_path_search_dfs_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [gpsd_pkg::NODE_W-1:0] node_a,
  input  logic [gpsd_pkg::NODE_W-1:0] node_b,
  output logic                        strobe,
  output logic [gpsd_pkg::NODE_W-1:0] path_node,
  output logic [1:0]                  status,
  output logic                        last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_POP = 3'd2;
  localparam logic [2:0] S_EMIT_TOP = 3'd3;
  localparam logic [2:0] S_EMIT_STK = 3'd4;

  localparam int NW = gpsd_pkg::NODE_W;
  localparam int CW = gpsd_pkg::EDGE_CW;
  localparam int VW = 1 << NW;

  logic [2:0]                          state;
  logic [CW-1:0]                       edge_count;
  logic [VW-1:0]                       visited;
  logic [gpsd_pkg::DEPTH_W-1:0]        depth;
  logic [NW-1:0]                       cur_node;
  logic [NW-1:0]                       target;
  logic [CW-1:0]                       issue_idx;
  logic [CW-1:0]                       chk_idx;
  logic                                pending;
  logic [gpsd_pkg::STACK_AW-1:0]       out_ptr;

  logic                                edge_we;
  logic [gpsd_pkg::EDGE_W-1:0]         edge_rdata;
  logic [NW-1:0]                       ea;
  logic [NW-1:0]                       eb;
  logic                                hit_a;
  logic                                hit_b;
  logic                                hit;
  logic [NW-1:0]                       nxt;
  logic                                full;
  logic                                take;
  logic                                can_issue;
  logic                                exhaust;
  logic                                stack_we;
  logic [gpsd_pkg::STACK_AW-1:0]       stack_waddr;
  logic [gpsd_pkg::FRAME_W-1:0]        stack_wdata;
  logic [gpsd_pkg::STACK_AW-1:0]       stack_raddr;
  logic [gpsd_pkg::FRAME_W-1:0]        stack_rdata;
  logic [gpsd_pkg::DEPTH_W-1:0]        depth_m1;
  logic [gpsd_pkg::DEPTH_W-1:0]        depth_m2;
  logic [CW-1:0]                       edges_max;
  logic                                strobe_next;

  assign edges_max = CW'(gpsd_pkg::EDGES);
  assign busy = (state != S_IDLE);

  assign edge_we = (state == S_IDLE) && start && (opcode == gpsd_pkg::OP_LOAD) &&
                   (edge_count != edges_max);

  gpsd_ram #(
    .WIDTH(gpsd_pkg::EDGE_W),
    .DEPTH(gpsd_pkg::EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_count[gpsd_pkg::EDGE_AW-1:0]),
    .wdata ({node_a, node_b}),
    .raddr (issue_idx[gpsd_pkg::EDGE_AW-1:0]),
    .rdata (edge_rdata)
  );

  assign ea = edge_rdata[gpsd_pkg::EDGE_W-1:NW];
  assign eb = edge_rdata[NW-1:0];
  assign hit_a = pending && (ea == cur_node) && !visited[eb];
  assign hit_b = pending && (eb == cur_node) && !visited[ea];
  assign hit = hit_a || hit_b;
  assign nxt = hit_a ? eb : ea;
  assign full = (depth == gpsd_pkg::DEPTH_W'(gpsd_pkg::STACK_SLOTS));
  assign take = hit && !full;
  assign can_issue = (issue_idx < edge_count);
  assign exhaust = (!pending && !can_issue) || (hit && full);

  assign depth_m1 = depth - gpsd_pkg::DEPTH_W'(1);
  assign depth_m2 = depth - gpsd_pkg::DEPTH_W'(2);

  assign stack_we = (state == S_SCAN) && take;
  assign stack_waddr = depth_m1[gpsd_pkg::STACK_AW-1:0];
  assign stack_wdata = {cur_node, chk_idx + CW'(1)};

  always_comb begin
    if (state == S_EMIT_STK) begin
      stack_raddr = out_ptr - gpsd_pkg::STACK_AW'(1);
    end else begin
      stack_raddr = depth_m2[gpsd_pkg::STACK_AW-1:0];
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE: begin
        strobe_next = start &&
                      (((opcode == gpsd_pkg::OP_LOAD) && (edge_count == edges_max)) ||
                       ((opcode == gpsd_pkg::OP_SEARCH) && (node_a == node_b)));
      end
      S_SCAN: begin
        strobe_next = !take && exhaust && (depth == gpsd_pkg::DEPTH_W'(1));
      end
      S_EMIT_TOP, S_EMIT_STK: begin
        strobe_next = 1'b1;
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  gpsd_ram #(
    .WIDTH(gpsd_pkg::FRAME_W),
    .DEPTH(gpsd_pkg::STACK_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      edge_count <= '0;
      visited <= '0;
      depth <= '0;
      pending <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (opcode)
              gpsd_pkg::OP_LOAD: begin
                if (edge_count == edges_max) begin
                  path_node <= '0;
                  status <= gpsd_pkg::ST_FULL;
                  last <= 1'b1;
                end else begin
                  edge_count <= edge_count + CW'(1);
                end
              end
              gpsd_pkg::OP_SEARCH: begin
                visited <= VW'(1) << node_a;
                cur_node <= node_a;
                target <= node_b;
                issue_idx <= '0;
                pending <= 1'b0;
                if (node_a == node_b) begin
                  path_node <= node_a;
                  status <= gpsd_pkg::ST_OK;
                  last <= 1'b1;
                  depth <= '0;
                end else begin
                  depth <= gpsd_pkg::DEPTH_W'(1);
                  state <= S_SCAN;
                end
              end
              gpsd_pkg::OP_CLEAR: begin
                edge_count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (take) begin
            visited[nxt] <= 1'b1;
            cur_node <= nxt;
            depth <= depth + gpsd_pkg::DEPTH_W'(1);
            issue_idx <= '0;
            pending <= 1'b0;
            if (nxt == target) begin
              state <= S_EMIT_TOP;
            end
          end else if (exhaust) begin
            pending <= 1'b0;
            if (depth == gpsd_pkg::DEPTH_W'(1)) begin
              path_node <= '0;
              status <= gpsd_pkg::ST_NOPATH;
              last <= 1'b1;
              depth <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_POP;
            end
          end else if (can_issue) begin
            issue_idx <= issue_idx + CW'(1);
            chk_idx <= issue_idx;
            pending <= 1'b1;
          end else begin
            pending <= 1'b0;
          end
        end
        S_POP: begin
          cur_node <= stack_rdata[gpsd_pkg::FRAME_W-1:CW];
          issue_idx <= stack_rdata[CW-1:0];
          depth <= depth_m1;
          state <= S_SCAN;
        end
        S_EMIT_TOP: begin
          path_node <= cur_node;
          status <= gpsd_pkg::ST_OK;
          last <= 1'b0;
          out_ptr <= depth_m2[gpsd_pkg::STACK_AW-1:0];
          state <= S_EMIT_STK;
        end
        S_EMIT_STK: begin
          path_node <= stack_rdata[gpsd_pkg::FRAME_W-1:CW];
          status <= gpsd_pkg::ST_OK;
          last <= (out_ptr == '0);
          if (out_ptr == '0) begin
            depth <= '0;
            state <= S_IDLE;
          end else begin
            out_ptr <= out_ptr - gpsd_pkg::STACK_AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cur_visited: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> visited[cur_node])
    else $error("Current search node is not marked visited.");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_idx <= edge_count))
    else $error("Edge scan index ran past the edge count.");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (depth != '0) && (depth <= gpsd_pkg::DEPTH_W'(gpsd_pkg::STACK_SLOTS)))
    else $error("Stack depth out of range during a search.");

  a_full_after_load: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == gpsd_pkg::ST_FULL)) |->
      ($past(opcode) == gpsd_pkg::OP_LOAD) && $past(start) && !$past(busy))
    else $error("Store-full status without a preceding load.");

  a_found_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_TOP) |=> strobe && !last && (state == S_EMIT_STK))
    else $error("Found path did not start emitting.");

endmodule
